// File: hw/rtl/ers_pkg.sv
package ers_pkg;

  localparam int CB = 16;          // coordinate bits
  localparam int WB = CB + 1;      // box width / height bits
  localparam int PB = 2 * WB;      // squared extent bits
  localparam int XB = 4 * WB;      // radicand bits
  localparam int SQ = 2 * WB;      // square root bits
  localparam int QB = WB;          // quotient bits

  // register word indexes
  localparam logic [1:0] REG_AX = 2'd0;
  localparam logic [1:0] REG_AY = 2'd1;
  localparam logic [1:0] REG_BX = 2'd2;
  localparam logic [1:0] REG_BY = 2'd3;

  typedef struct packed {
    logic signed [CB-1:0] row;
    logic                 inbox;
    logic signed [CB-1:0] x0;
    logic [WB-1:0]        w;
    logic [WB-1:0]        h;
  } ers_side_t;

endpackage

// File: hw/rtl/ers_front.sv
module ers_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [ers_pkg::CB-1:0] ax,
  input  logic signed [ers_pkg::CB-1:0] ay,
  input  logic signed [ers_pkg::CB-1:0] bx,
  input  logic signed [ers_pkg::CB-1:0] by,
  input  logic                         vld_in,
  input  logic signed [ers_pkg::CB-1:0] row_in,
  output logic                         vld_out,
  output logic [ers_pkg::XB-1:0]       x_out,
  output ers_pkg::ers_side_t           side_out
);
  import ers_pkg::*;

  logic signed [CB-1:0] x0, x1, y0, y1;
  logic signed [CB+2:0] ty, f, fa;
  logic [WB-1:0] w_c, h_c, d_c;

  logic [3:0]    vld_r;
  ers_side_t     side1_r, side2_r, side3_r, side4_r;
  logic [WB-1:0] d1_r;
  logic [PB-1:0] ww2_r, g2_r;
  logic [PB+WB-1:0] plo3_r, phi3_r;
  logic [XB-1:0] x4_r;
  logic [PB+1:0] g_full;

  always_comb begin
    x0 = (ax < bx) ? ax : bx;
    x1 = (ax < bx) ? bx : ax;
    y0 = (ay < by) ? ay : by;
    y1 = (ay < by) ? by : ay;
    w_c = WB'({x1[CB-1], x1} - {x0[CB-1], x0}) + WB'(1);
    h_c = WB'({y1[CB-1], y1} - {y0[CB-1], y0}) + WB'(1);
    ty = (CB+3)'(row_in) - (CB+3)'(y0);
    // doubled distance of row center from the middle
    f = (ty <<< 1) + (CB+3)'(1) - $signed({2'b00, h_c});
    fa = f[CB+2] ? -f : f;
    d_c = (fa != '0) ? WB'(fa - (CB+3)'(1)) : '0;
    g_full = (PB+2)'(side1_r.h - d1_r) * (PB+2)'({1'b0, side1_r.h} + {1'b0, d1_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], vld_in};
    end
    side1_r.row   <= row_in;
    side1_r.inbox <= (row_in >= y0) && (row_in <= y1);
    side1_r.x0    <= x0;
    side1_r.w     <= w_c;
    side1_r.h     <= h_c;
    d1_r          <= d_c;
    // W*W and H*H - d*d
    side2_r <= side1_r;
    ww2_r   <= PB'(side1_r.w) * PB'(side1_r.w);
    g2_r    <= g_full[PB-1:0];
    // split product
    side3_r <= side2_r;
    plo3_r  <= (PB+WB)'(ww2_r) * (PB+WB)'(g2_r[WB-1:0]);
    phi3_r  <= (PB+WB)'(ww2_r) * (PB+WB)'(g2_r[PB-1:WB]);
    side4_r <= side3_r;
    x4_r    <= XB'(plo3_r) + (XB'(phi3_r) << WB);
  end

  assign vld_out  = vld_r[3];
  assign x_out    = x4_r;
  assign side_out = side4_r;

endmodule

// File: hw/rtl/ers_sqrt.sv
module ers_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_in,
  input  logic [ers_pkg::XB-1:0] x_in,
  input  ers_pkg::ers_side_t     side_in,
  output logic                   vld_out,
  output logic [ers_pkg::SQ-1:0] root_out,
  output ers_pkg::ers_side_t     side_out
);
  import ers_pkg::*;

  localparam int RB = SQ + 2;

  logic [SQ-1:0] vld_r;
  logic [RB-1:0] rem_r  [SQ];
  logic [SQ-1:0] root_r [SQ];
  logic [XB-1:0] x_r    [SQ];
  ers_side_t     side_r [SQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQ-2:0], vld_in};
    end
  end

  // one root bit per stage, most significant first
  for (genvar i = 0; i < SQ; i++) begin : g_stage
    logic [RB-1:0] rem_in, rem_nxt;
    logic [SQ-1:0] root_in, root_nxt;
    logic [XB-1:0] x_in_s;
    ers_side_t     side_in_s;
    logic [RB+1:0] acc, trial;

    if (i == 0) begin : g_first
      assign rem_in    = '0;
      assign root_in   = '0;
      assign x_in_s    = x_in;
      assign side_in_s = side_in;
    end else begin : g_next
      assign rem_in    = rem_r[i-1];
      assign root_in   = root_r[i-1];
      assign x_in_s    = x_r[i-1];
      assign side_in_s = side_r[i-1];
    end

    always_comb begin
      acc   = {rem_in, x_in_s[2*(SQ-1-i)+1 -: 2]};
      trial = (RB+2)'({root_in, 2'b01});
      if (acc >= trial) begin
        rem_nxt  = RB'(acc - trial);
        root_nxt = {root_in[SQ-2:0], 1'b1};
      end else begin
        rem_nxt  = RB'(acc);
        root_nxt = {root_in[SQ-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= rem_nxt;
      root_r[i] <= root_nxt;
      x_r[i]    <= x_in_s;
      side_r[i] <= side_in_s;
    end
  end

  assign vld_out  = vld_r[SQ-1];
  assign root_out = root_r[SQ-1];
  assign side_out = side_r[SQ-1];

endmodule

// File: hw/rtl/ers_div.sv
module ers_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_in,
  input  logic [ers_pkg::SQ-1:0] s_in,
  input  ers_pkg::ers_side_t     side_in,
  output logic                   vld_out,
  output logic [ers_pkg::QB-1:0] q_out,
  output ers_pkg::ers_side_t     side_out
);
  import ers_pkg::*;

  logic [QB-1:0] vld_r;
  logic [WB-1:0] rem_r  [QB];
  logic [QB-1:0] q_r    [QB];
  logic [SQ-1:0] s_r    [QB];
  ers_side_t     side_r [QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QB-2:0], vld_in};
    end
  end

  // quotient is below 2^QB, so the upper half starts as the remainder
  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [WB-1:0] rem_in, rem_nxt;
    logic [QB-1:0] q_in, q_nxt;
    logic [SQ-1:0] s_in_s;
    ers_side_t     side_in_s;
    logic [WB:0]   acc;

    if (j == 0) begin : g_first
      assign rem_in    = s_in[SQ-1:WB];
      assign q_in      = '0;
      assign s_in_s    = s_in;
      assign side_in_s = side_in;
    end else begin : g_next
      assign rem_in    = rem_r[j-1];
      assign q_in      = q_r[j-1];
      assign s_in_s    = s_r[j-1];
      assign side_in_s = side_r[j-1];
    end

    always_comb begin
      acc = {rem_in, s_in_s[QB-1-j]};
      if (acc >= {1'b0, side_in_s.h}) begin
        rem_nxt = WB'(acc - {1'b0, side_in_s.h});
        q_nxt   = {q_in[QB-2:0], 1'b1};
      end else begin
        rem_nxt = WB'(acc);
        q_nxt   = {q_in[QB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= rem_nxt;
      q_r[j]    <= q_nxt;
      s_r[j]    <= s_in_s;
      side_r[j] <= side_in_s;
    end
  end

  assign vld_out  = vld_r[QB-1];
  assign q_out    = q_r[QB-1];
  assign side_out = side_r[QB-1];

endmodule

// File: hw/rtl/ellipse_row_span_unit.sv
// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+-------------------------------
// input    | start, busy, in_row_y                   | start high, busy low at edge
// result   | out_strobe, out_row_echo, out_span_*    | out_strobe high, one cycle
// config   | psel penable pwrite paddr pwdata prdata | psel & penable & pwrite & pready
//
// A new row may start every cycle; busy is always low.
// Each row passes the front end, the square root (one bit per stage) and
// the divide (one quotient bit per stage), then the output register.
// Synchronous active-low reset clears the valid bits and the corner registers.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module ellipse_row_span_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ers_pkg::CB-1:0] in_row_y,
  output logic                          out_strobe,
  output logic signed [ers_pkg::CB-1:0] out_row_echo,
  output logic                          out_span_valid,
  output logic signed [ers_pkg::CB-1:0] out_span_start,
  output logic signed [ers_pkg::CB:0]   out_span_stop
);
  import ers_pkg::*;

  localparam int LAT = 4 + SQ + QB + 1;

  logic signed [CB-1:0] ax_r, ay_r, bx_r, by_r;
  logic wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_AX:  ax_r <= pwdata[CB-1:0];
        REG_AY:  ay_r <= pwdata[CB-1:0];
        REG_BX:  bx_r <= pwdata[CB-1:0];
        REG_BY:  by_r <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_AX:  prdata = 32'({ax_r});
      REG_AY:  prdata = 32'({ay_r});
      REG_BX:  prdata = 32'({bx_r});
      REG_BY:  prdata = 32'({by_r});
      default: prdata = '0;
    endcase
  end

  // setup, W^2 and H^2-d^2, radicand W^2*(H^2-d^2)
  logic          f_vld;
  logic [XB-1:0] f_x;
  ers_side_t     f_side;

  ers_front u_front (
    .clk(clk), .rst_n(rst_n),
    .ax(ax_r), .ay(ay_r), .bx(bx_r), .by(by_r),
    .vld_in(start & ~busy), .row_in(in_row_y),
    .vld_out(f_vld), .x_out(f_x), .side_out(f_side)
  );

  logic          s_vld;
  logic [SQ-1:0] s_root;
  ers_side_t     s_side;

  ers_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n),
    .vld_in(f_vld), .x_in(f_x), .side_in(f_side),
    .vld_out(s_vld), .root_out(s_root), .side_out(s_side)
  );

  // largest e with e*H <= isqrt(radicand)
  logic          d_vld;
  logic [QB-1:0] d_q;
  ers_side_t     d_side;

  ers_div u_div (
    .clk(clk), .rst_n(rst_n),
    .vld_in(s_vld), .s_in(s_root), .side_in(s_side),
    .vld_out(d_vld), .q_out(d_q), .side_out(d_side)
  );

  // round e down to the parity of the pixel grid; a grazed row keeps the
  // middle pixel(s), which is the same as taking the smallest legal e
  logic          par;
  logic [QB-1:0] emax;
  logic [WB:0]   lo_c, hi_c;
  logic signed [CB+1:0] start_c, stop_c;
  logic          strobe_r, valid_r;
  logic signed [CB-1:0] echo_r, start_r;
  logic signed [CB:0]   stop_r;

  always_comb begin
    par = ~d_side.w[0];
    if (d_q < QB'(par)) begin
      emax = QB'(par);
    end else if (d_q[0] != par) begin
      emax = d_q - QB'(1);
    end else begin
      emax = d_q;
    end
    lo_c    = ({1'b0, d_side.w} - (WB+1)'(1) - (WB+1)'(emax)) >> 1;
    hi_c    = ({1'b0, d_side.w} - (WB+1)'(1) + (WB+1)'(emax)) >> 1;
    start_c = (CB+2)'(d_side.x0) + $signed({1'b0, lo_c[WB-1:0]});
    stop_c  = (CB+2)'(d_side.x0) + $signed({1'b0, hi_c[WB-1:0]}) + (CB+2)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= d_vld;
    end
    echo_r  <= d_side.row;
    valid_r <= d_side.inbox;
    start_r <= d_side.inbox ? start_c[CB-1:0] : '0;
    stop_r  <= d_side.inbox ? stop_c[CB:0] : '0;
  end

  assign out_strobe     = strobe_r;
  assign out_row_echo   = echo_r;
  assign out_span_valid = valid_r;
  assign out_span_start = start_r;
  assign out_span_stop  = stop_r;

`ifndef SYNTH
  a_strobe_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result without a started row");

  a_span_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_span_valid) |-> (out_span_stop > (CB+1)'(out_span_start)))
    else $error("empty span in box");
`endif

endmodule

// File: test/tb_ellipse_row_span_unit.sv
`timescale 1ns / 100ps

module tb_ellipse_row_span_unit;
  import ers_pkg::*;

  // one expected span per accepted row query
  typedef struct {
    logic signed [CB-1:0] row;
    logic                 valid;
    logic signed [CB-1:0] x_first;
    logic signed [CB:0]   x_end;
  } span_t;

  class span_board;
    int signed ax, ay, bx, by;   // live corner values
    span_t     pending[$];
    int        mismatches;
    int        spans_seen;
    int        valid_spans;

    function new();
      ax = 0; ay = 0; bx = 0; by = 0;
      mismatches = 0; spans_seen = 0; valid_spans = 0;
    endfunction

    // (a*b)^2 at full precision
    function bit [127:0] sq_prod(longint a, longint b);
      bit [127:0] t;
      t = a * b;
      return t * t;
    endfunction

    function bit inside_ellipse(longint e, longint h, bit [127:0] wd2, bit [127:0] wh2);
      return (sq_prod(e, h) + wd2) <= wh2;
    endfunction

    function span_t predict_span(logic signed [CB-1:0] row);
      span_t r;
      longint x0, x1, y0, y1, y, w, h, f, d, p, lo, hi, mid, emax, s, t;
      bit [127:0] wd2, wh2;
      x0 = (ax < bx) ? ax : bx;  x1 = (ax < bx) ? bx : ax;
      y0 = (ay < by) ? ay : by;  y1 = (ay < by) ? by : ay;
      y = row;
      s = 0; t = 0;
      r.row = row;
      r.valid = 0;
      if (y >= y0 && y <= y1) begin
        w = x1 - x0 + 1;
        h = y1 - y0 + 1;
        f = 2 * y + 1 - 2 * y0 - h;
        if (f < 0) f = -f;
        d = (f > 0) ? f - 1 : 0;
        p = (w + 1) & 1;
        wd2 = sq_prod(w, d);
        wh2 = sq_prod(w, h);
        r.valid = 1;
        if (inside_ellipse(p, h, wd2, wh2)) begin
          lo = 0;
          hi = (w - 1 - p) / 2;
          while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (inside_ellipse(2 * mid + p, h, wd2, wh2)) lo = mid;
            else hi = mid - 1;
          end
          emax = 2 * lo + p;
          s = x0 + (w - 1 - emax) / 2;
          t = x0 + (w - 1 + emax) / 2 + 1;
        end else begin
          // grazed row: keep the middle pixel(s)
          s = x0 + (w - 1) / 2;
          t = x0 + w / 2 + 1;
        end
      end
      r.x_first = s[CB-1:0];
      r.x_end   = t[CB:0];
      return r;
    endfunction

    function void note_row(logic signed [CB-1:0] row);
      pending.insert(pending.size(), predict_span(row));
    endfunction

    function void check_span(span_t got);
      span_t exp;
      spans_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected span for row %0d", got.row);
        return;
      end
      exp = pending.pop_front();
      if (got.valid) valid_spans++;
      if (got.row !== exp.row || got.valid !== exp.valid ||
          got.x_first !== exp.x_first || got.x_end !== exp.x_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("span mismatch: exp row %0d v %0d [%0d,%0d) got row %0d v %0d [%0d,%0d)",
                   exp.row, exp.valid, exp.x_first, exp.x_end,
                   got.row, got.valid, got.x_first, got.x_end);
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 psel = 0;
  logic                 penable = 0;
  logic                 pwrite = 0;
  logic [3:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 start = 0;
  logic                 busy;
  logic signed [CB-1:0] in_row_y = '0;
  logic                 out_strobe;
  logic signed [CB-1:0] out_row_echo;
  logic                 out_span_valid;
  logic signed [CB-1:0] out_span_start;
  logic signed [CB:0]   out_span_stop;

  localparam int LATENCY = 4 + 3 * (CB + 1) + 1;

  span_board board = new();
  int        rows_sent = 0;
  int        settings_used = 0;

  ellipse_row_span_unit dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .in_row_y(in_row_y),
    .out_strobe(out_strobe), .out_row_echo(out_row_echo),
    .out_span_valid(out_span_valid), .out_span_start(out_span_start),
    .out_span_stop(out_span_stop)
  );

  always #10 clk = ~clk;

  // Monitor: values sampled at the edge are those of the cycle just ending.
  always @(posedge clk) begin
    span_t got;
    if (rst_n) begin
      if (start && !busy) board.note_row(in_row_y);
      if (out_strobe) begin
        got.row     = out_row_echo;
        got.valid   = out_span_valid;
        got.x_first = out_span_start;
        got.x_end   = out_span_stop;
        board.check_span(got);
      end
    end
  end

  // One APB write: setup then access, completes on the edge with pready high.
  task automatic reg_write(logic [1:0] idx, int signed value);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk);
  endtask

  // Drain the pipeline, then load a new box.
  task automatic set_box(int signed a_x, int signed a_y, int signed b_x, int signed b_y);
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    reg_write(REG_AX, a_x);
    reg_write(REG_AY, a_y);
    reg_write(REG_BX, b_x);
    reg_write(REG_BY, b_y);
    board.ax = $signed(a_x[CB-1:0]);
    board.ay = $signed(a_y[CB-1:0]);
    board.bx = $signed(b_x[CB-1:0]);
    board.by = $signed(b_y[CB-1:0]);
    settings_used++;
  endtask

  // One row query; start stays high across back-to-back transfers.
  task automatic send_row(int signed row, bit idle_ok);
    int gap;
    start    <= 1;
    in_row_y <= row[CB-1:0];
    do @(posedge clk); while (busy);
    rows_sent++;
    gap = idle_ok ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic sweep_box(int n, bit idle_ok);
    int signed lo, hi, r;
    lo = (board.ay < board.by) ? board.ay : board.by;
    hi = (board.ay < board.by) ? board.by : board.ay;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       r = $signed($urandom_range(0, 65535)) - 32768;
        1:       r = lo - $urandom_range(1, 3);
        2:       r = hi + $urandom_range(1, 3);
        default: r = lo + $urandom_range(0, hi - lo);
      endcase
      if (r < -32768) r = -32768;
      if (r > 32767) r = 32767;
      send_row(r, idle_ok);
    end
  endtask

  initial begin
    int signed cx, cy, bw, bh;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset box is a single pixel at the origin
    send_row(0, 0);
    send_row(-1, 0);
    send_row(1, 0);
    send_row(-32768, 0);
    send_row(32767, 0);

    // full coordinate range, corners swapped
    set_box(32767, 32767, -32768, -32768);
    send_row(-32768, 0);
    send_row(32767, 0);
    send_row(0, 0);
    send_row(-1, 0);
    send_row(16384, 0);

    // even width, with a row just outside the box at the top and bottom
    set_box(0, 0, 9, 2);
    for (int r = -1; r <= 3; r++) send_row(r, 1);
    // single column and single row
    set_box(5, -4, 5, 4);
    for (int r = -5; r <= 5; r += 2) send_row(r, 1);
    set_box(-20, 7, 20, 7);
    send_row(7, 0);
    send_row(6, 0);

    // random boxes, mostly small, a few up to full size
    for (int ph = 0; ph < 14; ph++) begin
      cx = $signed($urandom_range(0, 65535)) - 32768;
      cy = $signed($urandom_range(0, 65535)) - 32768;
      if (ph % 5 == 4) begin
        bw = $urandom_range(0, 65535);
        bh = $urandom_range(0, 65535);
      end else begin
        bw = $urandom_range(0, 40);
        bh = $urandom_range(0, 40);
      end
      if (cx + bw > 32767) cx = 32767 - bw;
      if (cy + bh > 32767) cy = 32767 - bh;
      if ($urandom_range(0, 1)) set_box(cx, cy, cx + bw, cy + bh);
      else set_box(cx + bw, cy + bh, cx, cy);
      // odd phases run without idle gaps
      sweep_box(123, ph % 2 == 0);
    end

    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("sent %0d row queries over %0d box settings; %0d spans checked, %0d inside a box",
             rows_sent, settings_used, board.spans_seen, board.valid_spans);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("ellipse_row_span_unit: match");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("ellipse_row_span_unit: mismatch");
    end
    $finish;
  end

  // guard against a hung pipeline
  initial begin
    #20ms;
    $display("ellipse_row_span_unit: mismatch");
    $finish;
  end

endmodule
